// File: rtl/sqct_pkg.sv
package sqct_pkg;

  localparam int TrigIterations = 16;
  localparam int CordW = 34;
  localparam int IdxW = 5;

  localparam logic signed [16:0] Deg360 = 17'sd23040;
  localparam logic signed [16:0] Deg270 = 17'sd17280;
  localparam logic signed [16:0] Deg180 = 17'sd11520;
  localparam logic signed [16:0] Deg90 = 17'sd5760;
  localparam logic signed [27:0] DegToRad = 28'sd74961321;
  localparam logic signed [CordW-1:0] CordicStart = 34'sd652032874;
  localparam logic signed [17:0] PivotOne = 18'sd32768;

  typedef enum logic [1:0] {
    CfgPivotX = 2'd0,
    CfgPivotY = 2'd1,
    CfgRectW  = 2'd2,
    CfgRectH  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] angle_deg;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;
  } out_res_t;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               neg;
  } side_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [IdxW-1:0] idx);
    logic signed [CordW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [36:0] rnd30(input logic signed [66:0] v);
    logic signed [66:0] t;
    t = (v + (67'sd1 <<< 29)) >>> 30;
    return t[36:0];
  endfunction

endpackage

// File: rtl/sqct_cell.sv
module sqct_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [sqct_pkg::IdxW-1:0]           idx_i,
  input  logic                                valid_i,
  input  logic signed [sqct_pkg::CordW-1:0]   x_i,
  input  logic signed [sqct_pkg::CordW-1:0]   y_i,
  input  logic signed [sqct_pkg::CordW-1:0]   z_i,
  input  sqct_pkg::side_t                     side_i,
  output logic                                valid_o,
  output logic signed [sqct_pkg::CordW-1:0]   x_o,
  output logic signed [sqct_pkg::CordW-1:0]   y_o,
  output logic signed [sqct_pkg::CordW-1:0]   z_o,
  output sqct_pkg::side_t                     side_o
);
  import sqct_pkg::*;

  logic                    valid_q;
  logic signed [CordW-1:0] x_q, y_q, z_q, x_d, y_d, z_d, dx, dy, ang;
  side_t                   side_q;

  always_comb begin
    dx  = y_i >>> idx_i;
    dy  = x_i >>> idx_i;
    ang = atan_q30(idx_i);
    if (!z_i[CordW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

// File: rtl/sqct_corner.sv
module sqct_corner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [sqct_pkg::CordW-1:0] c_i,
  input  logic signed [sqct_pkg::CordW-1:0] s_i,
  input  sqct_pkg::side_t                   side_i,
  output logic                              valid_o,
  output sqct_pkg::out_res_t                res_o
);
  import sqct_pkg::*;

  logic                    va_q, vb_q;
  logic signed [CordW-1:0] c, s;
  logic signed [65:0]      lc_q, rc_q, ls_q, rs_q, tc_q, bc_q, ts_q, bs_q;
  logic signed [31:0]      px_q, py_q;
  out_res_t                res_d, res_q;

  assign c = side_i.neg ? -c_i : c_i;
  assign s = side_i.neg ? -s_i : s_i;

  function automatic logic signed [31:0] fin(input logic signed [66:0] v,
                                             input logic signed [31:0] p);
    logic signed [36:0] r;
    logic signed [37:0] t;
    r = rnd30(v);
    t = {r[36], r} + {{6{p[31]}}, p};
    return sat32(t);
  endfunction

  always_comb begin
    res_d.corner0_x = fin(67'(lc_q) - 67'(ts_q), px_q);
    res_d.corner0_y = fin(67'(tc_q) + 67'(ls_q), py_q);
    res_d.corner1_x = fin(67'(rc_q) - 67'(ts_q), px_q);
    res_d.corner1_y = fin(67'(tc_q) + 67'(rs_q), py_q);
    res_d.corner2_x = fin(67'(rc_q) - 67'(bs_q), px_q);
    res_d.corner2_y = fin(67'(bc_q) + 67'(rs_q), py_q);
    res_d.corner3_x = fin(67'(lc_q) - 67'(bs_q), px_q);
    res_d.corner3_y = fin(67'(bc_q) + 67'(ls_q), py_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lc_q  <= side_i.left * c;
      rc_q  <= side_i.right * c;
      ls_q  <= side_i.left * s;
      rs_q  <= side_i.right * s;
      tc_q  <= side_i.top * c;
      bc_q  <= side_i.bottom * c;
      ts_q  <= side_i.top * s;
      bs_q  <= side_i.bottom * s;
      px_q  <= side_i.pos_x;
      py_q  <= side_i.pos_y;
      res_q <= res_d;
    end
  end

  assign valid_o = vb_q;
  assign res_o   = res_q;

endmodule

// File: rtl/sprite_quad_corner_transform.sv
// Sprite quad corner transform. Each request carries a sprite's world position,
// scale and rotation angle; the result holds its four rotated, translated corners.
// Both channels use valid and ready; a request is taken when in_valid_i and
// in_ready_o are high at a clock edge, and a result when out_valid_o and
// out_ready_i are high. The pivot and rectangle registers are written through
// the plain cfg port, and should only change while no request is in flight.
// The pipeline has two set-up stages (angle reduction and edge products), one
// cell per CORDIC iteration (16 cells), and two stages of corner products and
// saturation. One request is taken every cycle unless the output is stalled;
// the whole pipeline advances together, so the row of CORDIC cells takes one
// request per cycle under the same condition.
// Reset clears all valid flags and the configuration registers to zero.
// When the receiver stalls, the result is held and every stage holds with it,
// so in_ready_o falls in the same cycle.
module sprite_quad_corner_transform (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sqct_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sqct_pkg::out_res_t   out_res_o
);
  import sqct_pkg::*;

  logic [15:0] pivot_x_q, pivot_y_q, rect_w_q, rect_h_q;
  logic        en;

  logic signed [16:0] ang, r1, r2, rf;
  logic               neg;
  logic signed [32:0] wsx, hsy;

  logic               v0_q, neg0_q;
  logic signed [16:0] rf0_q;
  logic signed [32:0] wsx0_q, hsy0_q;
  logic signed [31:0] px0_q, py0_q;

  logic signed [44:0] zp, zr;
  logic signed [17:0] fxl, fxr, fyt, fyb;
  logic signed [50:0] el, er, et, eb;
  side_t              side1_d, side1_q;
  logic               v1_q;
  logic signed [CordW-1:0] z1_q;

  logic                    cv [TrigIterations+1];
  logic signed [CordW-1:0] cx [TrigIterations+1];
  logic signed [CordW-1:0] cy [TrigIterations+1];
  logic signed [CordW-1:0] cz [TrigIterations+1];
  side_t                   cs [TrigIterations+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= '0;
      pivot_y_q <= '0;
      rect_w_q  <= '0;
      rect_h_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPivotX: pivot_x_q <= cfg_data_i;
        CfgPivotY: pivot_y_q <= cfg_data_i;
        CfgRectW:  rect_w_q  <= cfg_data_i;
        CfgRectH:  rect_h_q  <= cfg_data_i;
        default:   pivot_x_q <= pivot_x_q;
      endcase
    end
  end

  always_comb begin
    ang = {in_req_i.angle_deg[15], in_req_i.angle_deg};
    r1  = ang[16] ? ang + Deg360 : ang;
    if (r1[16]) begin
      r2 = r1 + Deg360;
    end else if (r1 >= Deg360) begin
      r2 = r1 - Deg360;
    end else begin
      r2 = r1;
    end
    neg = 1'b0;
    if (r2 > Deg90 && r2 <= Deg270) begin
      rf  = r2 - Deg180;
      neg = 1'b1;
    end else if (r2 > Deg270) begin
      rf = r2 - Deg360;
    end else begin
      rf = r2;
    end
    wsx = $signed({1'b0, rect_w_q}) * in_req_i.scale_x;
    hsy = $signed({1'b0, rect_h_q}) * in_req_i.scale_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rf0_q   <= rf;
      neg0_q  <= neg;
      wsx0_q  <= wsx;
      hsy0_q  <= hsy;
      px0_q   <= in_req_i.pos_x;
      py0_q   <= in_req_i.pos_y;
      z1_q    <= zr[CordW-1:0];
      side1_q <= side1_d;
    end
  end

  always_comb begin
    zp  = rf0_q * DegToRad;
    zr  = (zp + 45'sd128) >>> 8;
    fxr = $signed({2'b00, pivot_x_q});
    fxl = fxr - PivotOne;
    fyt = $signed({2'b00, pivot_y_q});
    fyb = fyt - PivotOne;
    el  = (fxl * wsx0_q + (51'sd1 <<< 18)) >>> 19;
    er  = (fxr * wsx0_q + (51'sd1 <<< 18)) >>> 19;
    et  = (fyt * hsy0_q + (51'sd1 <<< 18)) >>> 19;
    eb  = (fyb * hsy0_q + (51'sd1 <<< 18)) >>> 19;
    side1_d.left   = el[31:0];
    side1_d.right  = er[31:0];
    side1_d.top    = et[31:0];
    side1_d.bottom = eb[31:0];
    side1_d.pos_x  = px0_q;
    side1_d.pos_y  = py0_q;
    side1_d.neg    = neg0_q;
  end

  assign cv[0] = v1_q;
  assign cx[0] = CordicStart;
  assign cy[0] = '0;
  assign cz[0] = z1_q;
  assign cs[0] = side1_q;

  for (genvar g = 0; g < TrigIterations; g++) begin : g_cell
    sqct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (IdxW'(g)),
      .valid_i (cv[g]),
      .x_i     (cx[g]),
      .y_i     (cy[g]),
      .z_i     (cz[g]),
      .side_i  (cs[g]),
      .valid_o (cv[g+1]),
      .x_o     (cx[g+1]),
      .y_o     (cy[g+1]),
      .z_o     (cz[g+1]),
      .side_o  (cs[g+1])
    );
  end

  sqct_corner u_corner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[TrigIterations]),
    .c_i     (cx[TrigIterations]),
    .s_i     (cy[TrigIterations]),
    .side_i  (cs[TrigIterations]),
    .valid_o (out_valid_o),
    .res_o   (out_res_o)
  );

`ifndef ASSERT_OFF
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Pipeline stalled without a held result.");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == CfgPivotX |=> pivot_x_q == $past(cfg_data_i))
    else $error("Pivot x register missed a write.");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && in_ready_o |=> v1_q)
    else $error("Request lost between set-up stages.");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sqct_pkg::*;

  localparam int NumRandom = 1950;
  localparam int StallLimit = 20000;
  localparam int LongHold = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_res_t out_res_o;

  sprite_quad_corner_transform dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] piv_x, piv_y, rw, rh;
  in_req_t pending_reqs[$];
  out_res_t corners_due[$];
  int errors = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit tx_steady = 0;
  bit rx_steady = 0;
  int rx_hold = 0;
  bit hold_req = 0;

  typedef longint signed sl_t;

  function automatic sl_t sat_q(sl_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sin_cos(sl_t a, output sl_t c, output sl_t s);
    sl_t atab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    sl_t r, x, y, z, dx, dy;
    bit flip;
    r = a % 23040;
    flip = 0;
    if (r < 0) r += 23040;
    if (r > 5760 && r <= 17280) begin
      r -= 11520;
      flip = 1;
    end else if (r > 17280) begin
      r -= 23040;
    end
    z = (r * 74961321 + 128) >>> 8;
    x = 652032874;
    y = 0;
    for (int i = 0; i < TrigIterations && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atab[i];
      end else begin
        x += dx; y -= dy; z += atab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic sl_t edge_off(logic [15:0] f, bit m1, logic [15:0] sz, sl_t sc);
    sl_t fv;
    fv = sl_t'({1'b0, f}) - (m1 ? 32768 : 0);
    return (fv * (sl_t'({1'b0, sz}) * sc) + (64'sd1 <<< 18)) >>> 19;
  endfunction

  function automatic out_res_t quad_corners(in_req_t q);
    sl_t xs[2], ys[2], c, s, vx, vy, px, py;
    logic [31:0] o[8];
    out_res_t r;
    xs[0] = edge_off(piv_x, 1, rw, sl_t'(q.scale_x));
    xs[1] = edge_off(piv_x, 0, rw, sl_t'(q.scale_x));
    ys[0] = edge_off(piv_y, 0, rh, sl_t'(q.scale_y));
    ys[1] = edge_off(piv_y, 1, rh, sl_t'(q.scale_y));
    sin_cos(sl_t'(q.angle_deg), c, s);
    px = sl_t'(q.pos_x);
    py = sl_t'(q.pos_y);
    for (int k = 0; k < 4; k++) begin
      vx = xs[(k == 1 || k == 2) ? 1 : 0];
      vy = ys[(k >= 2) ? 1 : 0];
      o[2*k] = 32'(sat_q(((vx * c - vy * s + (64'sd1 <<< 29)) >>> 30) + px));
      o[2*k+1] = 32'(sat_q(((vy * c + vx * s + (64'sd1 <<< 29)) >>> 30) + py));
    end
    r = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7]};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      corners_due.push_back(quad_corners(in_req_i));
    end
    if (!in_valid_i || in_ready_o) begin
      if (pending_reqs.size() > 0 && (tx_steady || $urandom_range(99) >= 28)) begin
        in_req_i <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_res_t w;
    if (out_valid_o && out_ready_i) begin
      if (corners_due.size() == 0) begin
        report_mismatch("unexpected request result", out_res_o[31:0], 32'd0);
      end else begin
        w = corners_due.pop_front();
        checked++;
        for (int f = 0; f < 8; f++) begin
          if (out_res_o[255-32*f -: 32] !== w[255-32*f -: 32]) begin
            report_mismatch($sformatf("corner%0d_%s", f / 2, (f % 2) ? "y" : "x"),
                            out_res_o[255-32*f -: 32], w[255-32*f -: 32]);
          end
        end
      end
    end
    if (hold_req && rx_hold == 0) rx_hold <= LongHold;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rx_steady || $urandom_range(99) >= 28;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPivotX: piv_x = val;
      CfgPivotY: piv_y = val;
      CfgRectW: rw = val;
      default: rh = val;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || corners_due.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic in_req_t rand_req();
    in_req_t q;
    q.pos_x = $urandom;
    q.pos_y = $urandom;
    q.scale_x = 16'($urandom);
    q.scale_y = 16'($urandom);
    q.angle_deg = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      q.pos_x = $signed($urandom_range(2000000)) - 1000000;
      q.pos_y = $signed($urandom_range(2000000)) - 1000000;
      q.scale_x = 16'($signed($urandom_range(1024)) - 512);
      q.scale_y = 16'($signed($urandom_range(1024)) - 512);
    end
    return q;
  endfunction

  task automatic set_cfg(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
    write_reg(CfgPivotX, a);
    write_reg(CfgPivotY, b);
    write_reg(CfgRectW, c);
    write_reg(CfgRectH, d);
  endtask

  initial begin
    in_req_t q;
    logic [15:0] angles[12] = '{16'h0000, 16'd5760, 16'd11520, 16'd17280, 16'd23040,
                                -16'sd5760, 16'h7fff, 16'h8000, 16'd5761, 16'd17281,
                                16'd1, 16'hffff};
    piv_x = 0; piv_y = 0; rw = 0; rh = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_steady = 1;
    rx_steady = 1;
    q = '{pos_x: 32'sd1000, pos_y: -32'sd1000, scale_x: 16'sd256, scale_y: 16'sd256,
          angle_deg: 16'sd100};
    pending_reqs.push_back(q);
    drain();
    set_cfg(16'd16384, 16'd16384, 16'd512, 16'd256);
    foreach (angles[i]) begin
      q = '{pos_x: 32'sd0, pos_y: 32'sd0, scale_x: 16'sd256, scale_y: -16'sd256,
            angle_deg: angles[i]};
      pending_reqs.push_back(q);
    end
    q = '{pos_x: 32'h7fffffff, pos_y: 32'h80000000, scale_x: 16'h7fff,
          scale_y: 16'h8000, angle_deg: 16'd0};
    pending_reqs.push_back(q);
    q = '{pos_x: 32'h80000000, pos_y: 32'h7fffffff, scale_x: 16'h8000,
          scale_y: 16'h7fff, angle_deg: 16'd11520};
    pending_reqs.push_back(q);
    drain();
    set_cfg(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_req());
    drain();
    set_cfg(16'd32768, 16'd0, 16'd0, 16'd4096);
    for (int i = 0; i < 4; i++) pending_reqs.push_back(rand_req());
    drain();
    tx_steady = 0;
    rx_steady = 0;
    for (int ph = 0; ph < 6; ph++) begin
      set_cfg(16'($urandom_range(65535)), 16'($urandom_range(32768)),
              16'($urandom_range(65535)), 16'($urandom_range(2048)));
      for (int i = 0; i < NumRandom / 6; i++) pending_reqs.push_back(rand_req());
      if (ph == 2) begin
        tx_steady = 1;
        rx_steady = 1;
        while (pending_reqs.size() > 250) @(posedge clk_i);
        hold_req = 1;
        wait (rx_hold > 0);
        hold_req = 0;
      end
      drain();
      tx_steady = 0;
      rx_steady = 0;
    end
    $display("checked %0d sprite results across several pivot and size settings,", checked);
    $display("including extreme registers, right angles, saturation and a long output stall.");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/sqct_pkg.sv
rtl/sqct_cell.sv
rtl/sqct_corner.sv
rtl/sprite_quad_corner_transform.sv
tb/sv/tb_top.sv
